// ----- hw/rtl/rgn_iso_pkg.sv -----
// ----------------------------------------------------------------------------
// rgn_iso_pkg
// Shared types, constants and helpers of the 3x3 region isolation sum block.
// ----------------------------------------------------------------------------
`default_nettype none

package rgn_iso_pkg;

  // Grid geometry
  localparam int unsigned ETA_BINS   = 22;
  localparam int unsigned PHI_BINS   = 18;
  localparam int unsigned GRID_DEPTH = ETA_BINS * PHI_BINS;
  localparam int unsigned ADDR_W     = $clog2(GRID_DEPTH);

  // Field widths
  localparam int unsigned IDX_W    = 5;
  localparam int unsigned ENERGY_W = 10;
  localparam int unsigned SUM_W    = 14;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 14;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_THR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ISO_THR    = 2'd1;

  // Command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Last and middle row / column positions of the 3x3 window walk
  localparam logic [1:0] WIN_LAST = 2'd2;
  localparam logic [1:0] WIN_MID  = 2'd1;

  typedef struct packed {
    logic                cmd;
    logic [IDX_W-1:0]    eta_index;
    logic [IDX_W-1:0]    phi_index;
    logic [ENERGY_W-1:0] region_energy;
  } in_t;

  typedef struct packed {
    logic [SUM_W-1:0]    window_sum;
    logic [ENERGY_W-1:0] seed_energy;
    logic                isolated;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LAST,
    ST_DONE
  } state_e;

  function automatic logic [ADDR_W-1:0] grid_addr(logic [IDX_W-1:0] eta,
                                                  logic [IDX_W-1:0] phi);
    return ADDR_W'(eta) * ADDR_W'(PHI_BINS) + ADDR_W'(phi);
  endfunction

  function automatic logic in_grid(logic [IDX_W-1:0] eta, logic [IDX_W-1:0] phi);
    return (int'(eta) < ETA_BINS) && (int'(phi) < PHI_BINS);
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/rgn_iso_ram.sv -----
// ----------------------------------------------------------------------------
// rgn_iso_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rgn_iso_ram #(
  parameter int unsigned Width = 10,
  parameter int unsigned Depth = 396,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] addr_i,
  input  wire logic [Width-1:0] wdata_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hw/rtl/region_3x3_isolation_sum_core.sv -----
// ----------------------------------------------------------------------------
// region_3x3_isolation_sum_core
// Region energy grid with 3x3 window sum and isolation flag.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (in_valid_i/in_ready_o) either write one region energy into
//   the eta x phi grid (cmd = write) or query a seed region (cmd = query).
//   A write gives no result. A query walks the 3x3 window through the single
//   grid RAM port, one read per cycle, and gives one result beat on
//   out_valid_o/out_ready_i. The walk steps through ST_READ, then ST_LAST
//   (ST_DONE while the result slot is full), which loads the result register;
//   no new item is taken until the block is back in ST_IDLE. Out-of-grid
//   writes are dropped; out-of-grid queries give an all-zero result.
//   The result sits in an output register: writes and a new query are taken
//   while it waits, and a query only stalls at its final step until the
//   receiver takes the previous result.
//   Configuration beats (cfg_valid_i/cfg_ready_o) are always taken; index
//   0 sets the region threshold, 1 the isolation threshold, others are
//   ignored. Write them only while the block is idle.
//   Reset clears both thresholds and the control state; grid contents are
//   undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module region_3x3_isolation_sum_core
  import rgn_iso_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire in_t                   in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output out_t                       out_data_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  state_e state_q, state_d;

  logic [ENERGY_W-1:0] region_thr_q;
  logic [SUM_W-1:0]    iso_thr_q;

  logic [IDX_W-1:0]    eta_q, eta_d;
  logic [IDX_W-1:0]    phi_q, phi_d;
  logic                inside_q, inside_d;
  logic [1:0]          row_q, row_d;
  logic [1:0]          col_q, col_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [ENERGY_W-1:0] seed_q, seed_d;
  logic                rd_valid_q, rd_valid_d;
  logic                rd_seed_q, rd_seed_d;
  logic                out_valid_q, out_valid_d;
  out_t                out_q, out_d;

  logic                in_acc;
  logic                ram_en, ram_we;
  logic [ADDR_W-1:0]   ram_addr;
  logic [ENERGY_W-1:0] ram_rdata;
  logic [ENERGY_W-1:0] cut_e;
  logic [SUM_W-1:0]    sum_now;
  logic [IDX_W:0]      eta_sum;
  logic                nb_ok;
  logic [IDX_W-1:0]    nb_eta, nb_phi;
  logic                slot_free;

  // ---------------------------------------------------------------- config
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_thr_q <= '0;
      iso_thr_q    <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_REGION_THR) begin
        region_thr_q <= cfg_data_i[ENERGY_W-1:0];
      end else if (cfg_index_i == CFG_ISO_THR) begin
        iso_thr_q <= cfg_data_i[SUM_W-1:0];
      end
    end
  end

  // ---------------------------------------------------------------- grid RAM
  rgn_iso_ram #(
    .Width (ENERGY_W),
    .Depth (GRID_DEPTH)
  ) u_grid (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (in_data_i.region_energy),
    .rdata_o (ram_rdata)
  );

  // Window neighbour of the current walk position
  always_comb begin
    eta_sum = {1'b0, eta_q} + (IDX_W+1)'(row_q);
    nb_ok   = inside_q && (eta_sum != '0) && (int'(eta_sum) <= ETA_BINS);
    nb_eta  = IDX_W'(eta_sum - (IDX_W+1)'(1));
    unique case (col_q)
      2'd0:    nb_phi = (phi_q == '0) ? IDX_W'(PHI_BINS - 1) : phi_q - IDX_W'(1);
      2'd2:    nb_phi = (int'(phi_q) == PHI_BINS - 1) ? '0 : phi_q + IDX_W'(1);
      default: nb_phi = phi_q;
    endcase
  end

  // Threshold the beat returned by the RAM
  assign cut_e   = (ram_rdata < region_thr_q) ? '0 : ram_rdata;
  assign sum_now = rd_valid_q ? sum_q + SUM_W'(cut_e) : sum_q;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------- control
  always_comb begin
    state_d     = state_q;
    eta_d       = eta_q;
    phi_d       = phi_q;
    inside_d    = inside_q;
    row_d       = row_q;
    col_d       = col_q;
    sum_d       = sum_now;
    seed_d      = (rd_valid_q && rd_seed_q) ? cut_e : seed_q;
    rd_valid_d  = 1'b0;
    rd_seed_d   = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    ram_en      = 1'b0;
    ram_we      = 1'b0;
    ram_addr    = grid_addr(in_data_i.eta_index, in_data_i.phi_index);

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data_i.cmd == CMD_WRITE) begin
            ram_en = in_grid(in_data_i.eta_index, in_data_i.phi_index);
            ram_we = 1'b1;
          end else begin
            eta_d    = in_data_i.eta_index;
            phi_d    = in_data_i.phi_index;
            inside_d = in_grid(in_data_i.eta_index, in_data_i.phi_index);
            row_d    = '0;
            col_d    = '0;
            sum_d    = '0;
            seed_d   = '0;
            state_d  = ST_READ;
          end
        end
      end
      ST_READ: begin
        ram_addr   = grid_addr(nb_eta, nb_phi);
        ram_en     = nb_ok;
        rd_valid_d = nb_ok;
        rd_seed_d  = (row_q == WIN_MID) && (col_q == WIN_MID);
        // advance the walk, row by row
        if (col_q == WIN_LAST) begin
          col_d = '0;
          row_d = row_q + 2'd1;
          if (row_q == WIN_LAST) begin
            state_d = ST_LAST;
          end
        end else begin
          col_d = col_q + 2'd1;
        end
      end
      ST_LAST, ST_DONE: begin
        if (slot_free) begin
          out_valid_d        = 1'b1;
          out_d.window_sum   = sum_now;
          out_d.seed_energy  = seed_d;
          out_d.isolated     = inside_q && (iso_thr_q != '0) && (sum_now < iso_thr_q);
          state_d            = ST_IDLE;
        end else begin
          // hold the absorbed sum until the previous result is taken
          state_d = ST_DONE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rd_valid_q  <= 1'b0;
      rd_seed_q   <= 1'b0;
      out_valid_q <= 1'b0;
      row_q       <= '0;
      col_q       <= '0;
      inside_q    <= 1'b0;
      sum_q       <= '0;
      seed_q      <= '0;
    end else begin
      state_q     <= state_d;
      rd_valid_q  <= rd_valid_d;
      rd_seed_q   <= rd_seed_d;
      out_valid_q <= out_valid_d;
      row_q       <= row_d;
      col_q       <= col_d;
      inside_q    <= inside_d;
      sum_q       <= sum_d;
      seed_q      <= seed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    eta_q <= eta_d;
    phi_q <= phi_d;
    out_q <= out_d;
  end

  // ---------------------------------------------------------------- checks
  a_ram_addr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_en |-> (int'(ram_addr) < GRID_DEPTH))
    else $error("grid RAM accessed beyond its depth");

  a_no_write_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> !(ram_en && ram_we))
    else $error("grid write during window walk");

  a_read_beat_from_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_valid_q |-> $past(state_q == ST_READ))
    else $error("read data tagged valid outside window walk");

  a_result_from_final_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_LAST || state_q == ST_DONE))
    else $error("result raised outside final step");

  a_sum_covers_seed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.window_sum >= SUM_W'(out_q.seed_energy)))
    else $error("window sum below seed energy");

endmodule

`default_nettype wire
